// ===== rtl/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer burst sequencer package
// Holds the shared types, the request codes and the register map.
// ----------------------------------------------------------------------------
package bbs_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef enum logic [2:0] {
      REG_PULSE_HIGH   = 3'd0,
      REG_PULSE_LOW    = 3'd1,
      REG_PULSES       = 3'd2,
      REG_REPEATS      = 3'd3,
      REG_REPEAT_GAP   = 3'd4,
      REG_MUTE         = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0] pulse_high_ticks;
      logic [15:0] pulse_low_ticks;
      logic [15:0] pulses_per_burst;
      logic [15:0] burst_repeats;
      logic [15:0] repeat_gap_ticks;
      logic        mute;
   } cfg_type;

endpackage

// ===== rtl/buzzer_burst_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Buzzer burst sequencer
// Plays bursts of buzzer pulses with gaps between bursts, and keeps the
// charge indicator.
//
//   Channel  Direction  Handshake                       Payload
//   req      in         req_valid / req_stall           type, portable, charging
//   rsp      out        rsp_valid / rsp_stall           buzzer_on, busy_res, charge_flag
//   csr      in/out     psel / penable / pwrite / pready register writes and reads
//
// Each transfer passes an input register and then a result register before
// its result is presented. One request is taken every cycle while req_stall
// is low. Reset clears the counters, levels and valid flags, but not the
// payload registers. A stalled result holds both stages, and req_stall rises
// only when both are full.
// ----------------------------------------------------------------------------
module buzzer_burst_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic                           req_portable,
   input  logic                           req_charging,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_buzzer_on,
   output logic                           rsp_busy_res,
   output logic                           rsp_charge_flag,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bbs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bbs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bbs_pkg::*;

   cfg_type cfg;

   logic        in_valid_ff;
   logic        in_type_ff;
   logic        in_portable_ff;
   logic        in_charging_ff;
   logic        out_valid_ff;
   logic        out_buzzer_ff;
   logic        out_busy_ff;
   logic        out_charge_ff;

   logic [16:0] repeats_ff;
   logic [15:0] pulses_ff;
   logic [15:0] gap_ff;
   logic [16:0] period_ff;
   logic        charge_ff;
   logic        buzzer_ff;

   logic [16:0] repeats_in;
   logic [15:0] pulses_in;
   logic [15:0] gap_in;
   logic [16:0] period_in;
   logic        charge_in;
   logic        buzzer_in;

   logic [16:0] repeats_dec;
   logic [16:0] period_dec;
   logic        advance;
   logic        req_accept;

   bbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   assign repeats_dec = repeats_ff - 17'd1;
   assign period_dec  = period_ff - 17'd1;

   always_comb begin
      repeats_in = repeats_ff;
      pulses_in  = pulses_ff;
      gap_in     = gap_ff;
      period_in  = period_ff;
      charge_in  = charge_ff;
      buzzer_in  = buzzer_ff;
      if (in_type_ff == REQ_START) begin
         repeats_in = {1'b0, cfg.burst_repeats} + 17'd1;
      end else begin
         if ((repeats_ff != '0) && (pulses_ff == '0)) begin
            if (gap_ff == '0) begin
               repeats_in = repeats_dec;
               if (repeats_dec != '0) begin
                  pulses_in = cfg.pulses_per_burst;
                  gap_in    = cfg.repeat_gap_ticks;
               end
            end else begin
               gap_in = gap_ff - 16'd1;
            end
         end
         charge_in = in_charging_ff ? ~charge_ff : 1'b1;
         if (in_portable_ff) begin
            buzzer_in = charge_in;
         end else if (pulses_in != '0) begin
            if (period_ff == '0) begin
               period_in = {1'b0, cfg.pulse_high_ticks} + {1'b0, cfg.pulse_low_ticks};
               pulses_in = pulses_in - 16'd1;
               buzzer_in = 1'b0;
            end else begin
               period_in = period_dec;
               if ((period_dec == {1'b0, cfg.pulse_high_ticks}) && !cfg.mute) begin
                  buzzer_in = 1'b1;
               end
            end
         end else begin
            buzzer_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         repeats_ff   <= '0;
         pulses_ff    <= '0;
         gap_ff       <= '0;
         period_ff    <= '0;
         charge_ff    <= 1'b0;
         buzzer_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            repeats_ff   <= repeats_in;
            pulses_ff    <= pulses_in;
            gap_ff       <= gap_in;
            period_ff    <= period_in;
            charge_ff    <= charge_in;
            buzzer_ff    <= buzzer_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff     <= req_type;
         in_portable_ff <= req_portable;
         in_charging_ff <= req_charging;
      end
      if (advance) begin
         out_buzzer_ff <= buzzer_in;
         out_busy_ff   <= (repeats_in != '0) | (pulses_in != '0);
         out_charge_ff <= charge_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_buzzer_on   = out_buzzer_ff;
   assign rsp_busy_res    = out_busy_ff;
   assign rsp_charge_flag = out_charge_ff;

endmodule

// ===== rtl/bbs_csr.sv =====
// ----------------------------------------------------------------------------
// Buzzer burst sequencer register file
// Holds the six configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module bbs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bbs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bbs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output bbs_pkg::cfg_type               cfg
);
   import bbs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_PULSE_HIGH: cfg_in.pulse_high_ticks = pwdata[15:0];
            REG_PULSE_LOW:  cfg_in.pulse_low_ticks  = pwdata[15:0];
            REG_PULSES:     cfg_in.pulses_per_burst = pwdata[15:0];
            REG_REPEATS:    cfg_in.burst_repeats    = pwdata[15:0];
            REG_REPEAT_GAP: cfg_in.repeat_gap_ticks = pwdata[15:0];
            REG_MUTE:       cfg_in.mute             = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PULSE_HIGH: prdata = {16'd0, cfg_ff.pulse_high_ticks};
         REG_PULSE_LOW:  prdata = {16'd0, cfg_ff.pulse_low_ticks};
         REG_PULSES:     prdata = {16'd0, cfg_ff.pulses_per_burst};
         REG_REPEATS:    prdata = {16'd0, cfg_ff.burst_repeats};
         REG_REPEAT_GAP: prdata = {16'd0, cfg_ff.repeat_gap_ticks};
         REG_MUTE:       prdata = {31'd0, cfg_ff.mute};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
